@@ rtl/chbg_pkg.sv @@
`default_nettype none

package chbg_pkg;

  // grid position bits after the coordinate divide, saturates at 2047
  localparam int GRID_BITS = 11;
  localparam int CODE_W = 16;
  localparam int NUM_CHAN = 3;

  typedef struct packed {
    logic [CODE_W-1:0] scale;
    logic [CODE_W-1:0] offset;
  } code_cfg_t;

endpackage

`default_nettype wire

@@ rtl/chbg_grid_div.sv @@
`default_nettype none

module chbg_grid_div #(
  parameter int NW = 28,
  parameter int DW = 16,
  parameter int QB = 11
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QB-1:0] quo_o
);

  localparam int RW = NW - 1;
  localparam int CW = ((RW > DW + QB) ? RW : DW + QB) + 1;

  logic [RW-1:0] rem_q  [QB];
  logic [QB-1:0] quo_q  [QB+1];
  logic          zero_q [QB+1];
  logic          max_q  [QB+1];

  // stage zero: sign and overflow check
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i[RW-1:0];
      quo_q[0]  <= '0;
      zero_q[0] <= num_i[NW-1];
      max_q[0]  <= !num_i[NW-1] && (CW'(num_i[RW-1:0]) >= (CW'(den_i) << QB));
    end
  end

  // one quotient bit per stage
  for (genvar i = 1; i <= QB; i++) begin : g_stage
    localparam int K = QB - i;
    logic [CW-1:0] trial;
    logic          ge;

    assign trial = CW'(den_i) << K;
    assign ge    = CW'(rem_q[i-1]) >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[i]  <= quo_q[i-1] | (ge ? (QB'(1) << K) : QB'(0));
        zero_q[i] <= zero_q[i-1];
        max_q[i]  <= max_q[i-1];
      end
    end

    if (i < QB) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[i] <= ge ? RW'(CW'(rem_q[i-1]) - trial) : rem_q[i-1];
        end
      end
    end
  end

  assign quo_o = zero_q[QB] ? '0 : (max_q[QB] ? '1 : quo_q[QB]);

endmodule

`default_nettype wire

@@ rtl/chbg_level.sv @@
`default_nettype none

module chbg_level #(
  parameter int FB = 16
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [chbg_pkg::GRID_BITS-1:0]  xhd_i,
  input  logic [chbg_pkg::GRID_BITS-1:0]  yhd_i,
  input  logic [14:0]                     bar_i,
  output logic [FB+8:0]                   lv_o [chbg_pkg::NUM_CHAN]
);

  import chbg_pkg::*;

  localparam int LW   = FB + 9;
  localparam int SR   = FB - 2;
  localparam int SB   = FB - 8;
  localparam int A257 = (2 ** SR) / 257;
  localparam int B257 = (2 ** SR) % 257;
  localparam int A75  = (2 ** SB) / 75;
  localparam int B75  = (2 ** SB) % 75;
  localparam logic [17:0] M257 = 18'((2 ** 26 + 256) / 257);
  localparam logic [22:0] M75  = 23'((2 ** 29 + 74) / 75);

  function automatic logic [23:0] rgb(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    return {b, g, r};
  endfunction

  logic        ramp_d;
  logic [2:0]  useg_d;
  logic [23:0] ire_d;
  logic [6:0]  c_d;

  // region decode
  always_comb begin
    ramp_d = 1'b0;
    useg_d = 3'b000;
    ire_d  = '0;
    c_d    = '0;
    if (yhd_i < 11'd270) begin
      if (xhd_i < 11'd240)       ire_d = rgb(8'd15, 8'd15, 8'd15);
      else if (xhd_i < 11'd548)  ire_d = '0;
      else if (xhd_i < 11'd960)  ire_d = rgb(8'd100, 8'd100, 8'd100);
      else if (xhd_i < 11'd1130) ire_d = '0;
      else if (xhd_i < 11'd1198) ire_d = rgb(8'hFE, 8'hFE, 8'hFE);
      else if (xhd_i < 11'd1268) ire_d = '0;
      else if (xhd_i < 11'd1336) ire_d = rgb(8'd2, 8'd2, 8'd2);
      else if (xhd_i < 11'd1406) ire_d = '0;
      else if (xhd_i < 11'd1474) ire_d = rgb(8'd4, 8'd4, 8'd4);
      else if (xhd_i < 11'd1680) ire_d = '0;
      else                       ire_d = rgb(8'd15, 8'd15, 8'd15);
    end else if (yhd_i < 11'd360) begin
      if (xhd_i < 11'd240)       ire_d = rgb(8'd100, 8'd100, 8'd0);
      else if (xhd_i < 11'd446)  ire_d = '0;
      else if (xhd_i < 11'd1474) begin
        ramp_d = 1'b1;
        useg_d = 3'b111;
      end
      else if (xhd_i < 11'd1680) ire_d = rgb(8'd100, 8'd100, 8'd100);
      else                       ire_d = rgb(8'd100, 8'd0, 8'd0);
    end else if (yhd_i < 11'd450) begin
      if (xhd_i < 11'd240)       ire_d = rgb(8'd0, 8'd100, 8'd100);
      else if (xhd_i < 11'd446)  ire_d = rgb(8'd100, 8'd100, 8'd100);
      else if (xhd_i < 11'd1680) ire_d = rgb(8'd75, 8'd75, 8'd75);
      else                       ire_d = rgb(8'd0, 8'd0, 8'd100);
    end else begin
      if (xhd_i < 11'd240) begin
        c_d = 7'd40;
        useg_d = 3'b111;
      end else if (xhd_i < 11'd446) begin
        c_d = 7'd75;
        useg_d = 3'b111;
      end else if (xhd_i < 11'd652) begin
        c_d = 7'd75;
        useg_d = 3'b011;
      end else if (xhd_i < 11'd858) begin
        c_d = 7'd75;
        useg_d = 3'b110;
      end else if (xhd_i < 11'd1062) begin
        c_d = 7'd75;
        useg_d = 3'b010;
      end else if (xhd_i < 11'd1268) begin
        c_d = 7'd75;
        useg_d = 3'b101;
      end else if (xhd_i < 11'd1474) begin
        c_d = 7'd75;
        useg_d = 3'b001;
      end else if (xhd_i < 11'd1680) begin
        c_d = 7'd75;
        useg_d = 3'b100;
      end else begin
        c_d = 7'd40;
        useg_d = 3'b111;
      end
    end
  end

  logic        ramp0_q, ramp1_q, ramp2_q, ramp3_q, ramp4_q;
  logic [2:0]  useg0_q, useg1_q, useg2_q, useg3_q, useg4_q;
  logic [23:0] ire0_q, ire1_q, ire2_q, ire3_q, ire4_q;
  logic [10:0] u0_q;
  logic [6:0]  c0_q;
  logic [16:0] p1_q, p2_q;
  logic [21:0] k1_q, k2_q;
  logic [34:0] prodp2_q;
  logic [44:0] prodk2_q;
  logic [8:0]  qp_d, qp3_q, qp4_q, rp_d, rp3_q;
  logic [16:0] z1_d, z1_3_q;
  logic [15:0] qk_d, qk3_q, qk4_q;
  logic [6:0]  rk_d, rk3_q;
  logic [12:0] z2_d, z2_3_q;
  logic [34:0] pz1_4_q;
  logic [35:0] pz2_4_q;
  logic [LW-1:0] ra1_4_q, ra2_4_q, g_d;
  logic [LW-1:0] lv_q [NUM_CHAN];

  assign qp_d = prodp2_q[34:26];
  assign rp_d = 9'(p2_q - 17'(qp_d) * 17'd257);
  assign z1_d = 17'(rp_d) * 17'(B257) + 17'd128;
  assign qk_d = prodk2_q[44:29];
  assign rk_d = 7'(k2_q - 22'(qk_d) * 22'd75);
  assign z2_d = 13'(rk_d) * 13'(B75) + 13'd37;

  assign g_d = ramp4_q ?
      (LW'(qp4_q) << SR) + ra1_4_q + LW'(pz1_4_q[34:26]) :
      (LW'(qk4_q) << SB) + ra2_4_q + LW'(pz2_4_q[35:29]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ramp0_q <= ramp_d;
      useg0_q <= useg_d;
      ire0_q  <= ire_d;
      u0_q    <= xhd_i - 11'd446;
      c0_q    <= c_d;

      ramp1_q <= ramp0_q;
      useg1_q <= useg0_q;
      ire1_q  <= ire0_q;
      p1_q    <= 17'(u0_q) * 17'd100;
      k1_q    <= 22'(c0_q) * 22'(bar_i);

      ramp2_q  <= ramp1_q;
      useg2_q  <= useg1_q;
      ire2_q   <= ire1_q;
      p2_q     <= p1_q;
      k2_q     <= k1_q;
      prodp2_q <= 35'(p1_q) * 35'(M257);
      prodk2_q <= 45'(k1_q) * 45'(M75);

      ramp3_q <= ramp2_q;
      useg3_q <= useg2_q;
      ire3_q  <= ire2_q;
      qp3_q   <= qp_d;
      rp3_q   <= rp_d;
      z1_3_q  <= z1_d;
      qk3_q   <= qk_d;
      rk3_q   <= rk_d;
      z2_3_q  <= z2_d;

      ramp4_q <= ramp3_q;
      useg4_q <= useg3_q;
      ire4_q  <= ire3_q;
      qp4_q   <= qp3_q;
      qk4_q   <= qk3_q;
      pz1_4_q <= 35'(z1_3_q) * 35'(M257);
      pz2_4_q <= 36'(z2_3_q) * 36'(M75);
      ra1_4_q <= LW'(rp3_q) * LW'(A257);
      ra2_4_q <= LW'(rk3_q) * LW'(A75);

      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        lv_q[ch] <= useg4_q[ch] ? g_d :
            ({{(LW-8){ire4_q[ch*8+7]}}, ire4_q[ch*8 +: 8]} << FB);
      end
    end
  end

  assign lv_o = lv_q;

endmodule

`default_nettype wire

@@ rtl/chbg_code.sv @@
`default_nettype none

module chbg_code #(
  parameter int FB = 16
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [FB+8:0]                lv_i,
  input  chbg_pkg::code_cfg_t          cfg_i,
  output logic [chbg_pkg::CODE_W-1:0]  code_o
);

  import chbg_pkg::*;

  localparam int LW = FB + 9;
  localparam int PW = FB + 23;
  localparam logic [LW-1:0]  FULL = LW'(100) << FB;
  localparam logic [PW:0]    HALF = (PW + 1)'(50) << FB;
  localparam logic [23:0]    M100 = 24'((2 ** 30 + 99) / 100);

  logic          lo_d, hi_d;
  logic          lo1_q, hi1_q, lo2_q, hi2_q;
  logic [PW-1:0] prod_q;
  logic [PW:0]   sum;
  logic [22:0]   t;
  logic [46:0]   tm_q;

  assign lo_d = lv_i[LW-1] || (lv_i == '0);
  assign hi_d = !lv_i[LW-1] && (lv_i >= FULL);
  assign sum  = (PW + 1)'(prod_q) + HALF;
  assign t    = sum[FB+22:FB];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo1_q  <= lo_d;
      hi1_q  <= hi_d;
      prod_q <= PW'(lv_i[FB+6:0]) * PW'(cfg_i.scale);
      lo2_q  <= lo1_q;
      hi2_q  <= hi1_q;
      tm_q   <= 47'(t) * 47'(M100);
    end
  end

  assign code_o = cfg_i.offset + (lo2_q ? CODE_W'(0) :
                                  (hi2_q ? cfg_i.scale : tm_q[45:30]));

endmodule

`default_nettype wire

@@ rtl/hd_color_bar_pattern_generator_unit.sv @@
// HD color bar pattern generator
// input channel: in_valid_i / in_ready_o carry one pixel coordinate
// (pixel_x_i, pixel_y_i, row zero at the bottom) per transfer
// output channel: out_valid_o / out_ready_i carry red, green, blue and
// alpha codes for that pixel, in input order
// config: cfg_we_i writes cfg_wdata_i to the register at cfg_addr_i in a
// single cycle; write only while no pixel is in flight
// latency: 21 cycles from the input transfer to out_valid_o
// throughput: one pixel per cycle; the two coordinate dividers run one
// quotient bit per stage, 11 stages, then the level and code multipliers
// a stalled receiver freezes the whole pipeline and the output register,
// in_ready_o drops only while a result is waiting
// reset clears every config register to its default and empties the
// pipeline; no pixel is in flight afterwards
`default_nettype none

module hd_color_bar_pattern_generator_unit #(
  parameter int COORD_BITS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            cfg_we_i,
  input  logic [2:0]                                      cfg_addr_i,
  input  logic [((COORD_BITS > 15) ? COORD_BITS : 15)-1:0] cfg_wdata_i,
  input  logic                                            in_valid_i,
  output logic                                            in_ready_o,
  input  logic [COORD_BITS-1:0]                           pixel_x_i,
  input  logic [COORD_BITS-1:0]                           pixel_y_i,
  output logic                                            out_valid_o,
  input  logic                                            out_ready_i,
  output logic [chbg_pkg::CODE_W-1:0]                     red_o,
  output logic [chbg_pkg::CODE_W-1:0]                     green_o,
  output logic [chbg_pkg::CODE_W-1:0]                     blue_o,
  output logic [chbg_pkg::CODE_W-1:0]                     alpha_o
);

  import chbg_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int NW   = C + 12;
  localparam int LW   = FRACTION_BITS + 9;
  localparam int PIPE = GRID_BITS + 10;

  localparam logic [2:0] REG_RECT_LEFT     = 3'd0;
  localparam logic [2:0] REG_RECT_BOTTOM   = 3'd1;
  localparam logic [2:0] REG_RECT_WIDTH    = 3'd2;
  localparam logic [2:0] REG_RECT_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_BAR_INTENSITY = 3'd4;
  localparam logic [2:0] REG_OUTPUT_IRE    = 3'd5;
  localparam logic [2:0] REG_SAMPLE_DEPTH  = 3'd6;

  logic [C-1:0] left_q, bottom_q, width_q, height_q;
  logic [14:0]  bar_q;
  logic         ire_q, depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      bottom_q <= '0;
      width_q  <= C'(1920);
      height_q <= C'(1080);
      bar_q    <= 15'd19200;
      ire_q    <= 1'b0;
      depth_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_RECT_LEFT:     left_q   <= cfg_wdata_i[C-1:0];
        REG_RECT_BOTTOM:   bottom_q <= cfg_wdata_i[C-1:0];
        REG_RECT_WIDTH:    width_q  <= cfg_wdata_i[C-1:0];
        REG_RECT_HEIGHT:   height_q <= cfg_wdata_i[C-1:0];
        REG_BAR_INTENSITY: bar_q    <= cfg_wdata_i[14:0];
        REG_OUTPUT_IRE:    ire_q    <= cfg_wdata_i[0];
        REG_SAMPLE_DEPTH:  depth_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  logic [PIPE-1:0] vld_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // offset and scale onto the 1920x1080 grid
  logic [C:0]    dx, dy;
  logic [NW-1:0] nx_d, ny_d, nx_q, ny_q;
  logic [C-1:0]  den_x, den_y;

  assign dx    = {pixel_x_i[C-1], pixel_x_i} - {left_q[C-1], left_q};
  assign dy    = {pixel_y_i[C-1], pixel_y_i} - {bottom_q[C-1], bottom_q};
  assign nx_d  = {{(NW-C-1){dx[C]}}, dx} * NW'(1920);
  assign ny_d  = {{(NW-C-1){dy[C]}}, dy} * NW'(1080);
  assign den_x = (width_q == '0) ? C'(1) : width_q;
  assign den_y = (height_q == '0) ? C'(1) : height_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q <= nx_d;
      ny_q <= ny_d;
    end
  end

  logic [GRID_BITS-1:0] xhd, yhd;

  chbg_grid_div #(.NW(NW), .DW(C), .QB(GRID_BITS)) u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (nx_q),
    .den_i (den_x),
    .quo_o (xhd)
  );

  chbg_grid_div #(.NW(NW), .DW(C), .QB(GRID_BITS)) u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (ny_q),
    .den_i (den_y),
    .quo_o (yhd)
  );

  logic [LW-1:0] lv [NUM_CHAN];

  chbg_level #(.FB(FRACTION_BITS)) u_level (
    .clk_i (clk_i),
    .en_i  (en),
    .xhd_i (xhd),
    .yhd_i (yhd),
    .bar_i (bar_q),
    .lv_o  (lv)
  );

  code_cfg_t code_cfg;

  always_comb begin
    if (ire_q) begin
      code_cfg.scale  = depth_q ? CODE_W'(65535) : CODE_W'(255);
      code_cfg.offset = '0;
    end else begin
      code_cfg.scale  = depth_q ? CODE_W'(56064) : CODE_W'(219);
      code_cfg.offset = depth_q ? CODE_W'(4096) : CODE_W'(16);
    end
  end

  logic [CODE_W-1:0] code [NUM_CHAN];

  for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_code
    chbg_code #(.FB(FRACTION_BITS)) u_code (
      .clk_i  (clk_i),
      .en_i   (en),
      .lv_i   (lv[ch]),
      .cfg_i  (code_cfg),
      .code_o (code[ch])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[PIPE-2:0], in_valid_i};
      out_valid_q <= vld_q[PIPE-1];
    end
  end

  logic [CODE_W-1:0] red_q, green_q, blue_q, alpha_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      red_q   <= code[0];
      green_q <= code[1];
      blue_q  <= code[2];
      alpha_q <= depth_q ? CODE_W'(65535) : CODE_W'(255);
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign alpha_o     = alpha_q;

  a_alpha_opaque : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (alpha_o == CODE_W'(255) || alpha_o == CODE_W'(65535)))
    else $error("alpha not opaque");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_result_from_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(vld_q[PIPE-1]))
    else $error("result without a pixel in the last stage");

endmodule

`default_nettype wire

@@ test/hd_color_bar_pattern_generator_unit_test.sv @@
`default_nettype none

module hd_color_bar_pattern_generator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import chbg_pkg::*;

  typedef enum logic [2:0] {
    REG_LEFT = 3'd0, REG_BOTTOM = 3'd1, REG_WIDTH = 3'd2, REG_HEIGHT = 3'd3,
    REG_INTENSITY = 3'd4, REG_FULL_RANGE = 3'd5, REG_DEPTH = 3'd6, REG_UNUSED = 3'd7
  } reg_index_e;

  typedef struct packed {
    logic [CODE_W-1:0] red;
    logic [CODE_W-1:0] green;
    logic [CODE_W-1:0] blue;
    logic [CODE_W-1:0] alpha;
  } pixel_codes_t;

  localparam longint IRE_ONE = 64'd65536;
  localparam longint IRE_FULL = 100 * IRE_ONE;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_addr_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [15:0] pixel_x_i = '0;
  logic [15:0] pixel_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [CODE_W-1:0] red_o, green_o, blue_o, alpha_o;

  hd_color_bar_pattern_generator_unit dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow copy of the configuration
  longint m_left, m_bottom, m_width, m_height, m_intensity;
  bit m_full_range, m_depth;

  pixel_codes_t expected_codes[$];
  int unsigned errors = 0;
  int unsigned pixels_sent = 0;
  int unsigned pixels_checked = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  function automatic longint level_to_code(longint lv, longint scale);
    if (lv <= 0) return 0;
    if (lv >= IRE_FULL) return scale;
    return (lv * scale * 2 + IRE_FULL) / (2 * IRE_FULL);
  endfunction

  function automatic pixel_codes_t predict_codes(logic [15:0] px, logic [15:0] py);
    longint x, y, w, h, xhd, yhd, v;
    longint lv[3];
    longint code[3];
    pixel_codes_t res;
    x = longint'($signed(px));
    y = longint'($signed(py));
    w = (m_width == 0) ? 1 : m_width;
    h = (m_height == 0) ? 1 : m_height;
    xhd = (x - m_left) * 1920 / w;
    yhd = (y - m_bottom) * 1080 / h;
    if (yhd < 270) begin
      if (xhd < 240) v = 15;
      else if (xhd < 548) v = 0;
      else if (xhd < 960) v = 100;
      else if (xhd < 1130) v = 0;
      else if (xhd < 1198) v = -2;
      else if (xhd < 1268) v = 0;
      else if (xhd < 1336) v = 2;
      else if (xhd < 1406) v = 0;
      else if (xhd < 1474) v = 4;
      else if (xhd < 1680) v = 0;
      else v = 15;
      lv = '{v, v, v};
    end else if (yhd < 360) begin
      if (xhd < 240) lv = '{100, 100, 0};
      else if (xhd < 446) lv = '{0, 0, 0};
      else if (xhd < 1474) lv = '{-1, -1, -1};
      else if (xhd < 1680) lv = '{100, 100, 100};
      else lv = '{100, 0, 0};
    end else if (yhd < 450) begin
      if (xhd < 240) lv = '{0, 100, 100};
      else if (xhd < 446) lv = '{100, 100, 100};
      else if (xhd < 1680) lv = '{75, 75, 75};
      else lv = '{0, 0, 100};
    end else begin
      if (xhd < 240) lv = '{40, 40, 40};
      else if (xhd < 446) lv = '{75, 75, 75};
      else if (xhd < 652) lv = '{75, 75, 0};
      else if (xhd < 858) lv = '{0, 75, 75};
      else if (xhd < 1062) lv = '{0, 75, 0};
      else if (xhd < 1268) lv = '{75, 0, 75};
      else if (xhd < 1474) lv = '{75, 0, 0};
      else if (xhd < 1680) lv = '{0, 0, 75};
      else lv = '{40, 40, 40};
    end
    for (int c = 0; c < 3; c++) begin
      if (yhd >= 270 && yhd < 360 && xhd >= 446 && xhd < 1474)
        lv[c] = ((xhd - 446) * 100 * IRE_ONE * 2 + 1028) / (2 * 1028);
      else
        lv[c] = lv[c] * IRE_ONE;
      if (yhd >= 450)
        lv[c] = (lv[c] * m_intensity * 2 + 19200) / (2 * 19200);
      if (m_full_range) code[c] = level_to_code(lv[c], m_depth ? 65535 : 255);
      else if (m_depth) code[c] = 4096 + level_to_code(lv[c], 60160 - 4096);
      else code[c] = 16 + level_to_code(lv[c], 235 - 16);
    end
    res.red = code[0][15:0];
    res.green = code[1][15:0];
    res.blue = code[2][15:0];
    res.alpha = m_depth ? 16'hFFFF : 16'h00FF;
    return res;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    pixel_codes_t exp_c;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_codes.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        exp_c = expected_codes.pop_front();
        pixels_checked++;
        if (red_o !== exp_c.red) begin
          $error("red: expected %0d, got %0d", exp_c.red, red_o);
          errors++;
        end
        if (green_o !== exp_c.green) begin
          $error("green: expected %0d, got %0d", exp_c.green, green_o);
          errors++;
        end
        if (blue_o !== exp_c.blue) begin
          $error("blue: expected %0d, got %0d", exp_c.blue, blue_o);
          errors++;
        end
        if (alpha_o !== exp_c.alpha) begin
          $error("alpha: expected %0d, got %0d", exp_c.alpha, alpha_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // called at a rising edge; leaves valid high after the transfer
  task automatic send_pixel(logic [15:0] px, logic [15:0] py);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_x_i <= px;
    pixel_y_i <= py;
    expected_codes.push_back(predict_codes(px, py));
    pixels_sent++;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_codes.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_index_e idx, logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      REG_LEFT: m_left = longint'($signed(value));
      REG_BOTTOM: m_bottom = longint'($signed(value));
      REG_WIDTH: m_width = value;
      REG_HEIGHT: m_height = value;
      REG_INTENSITY: m_intensity = value[14:0];
      REG_FULL_RANGE: m_full_range = value[0];
      REG_DEPTH: m_depth = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [15:0] left, logic [15:0] bottom, logic [15:0] w,
                           logic [15:0] h, logic [15:0] inten, bit full, bit depth);
    drain();
    write_reg(REG_LEFT, left);
    write_reg(REG_BOTTOM, bottom);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_INTENSITY, inten);
    write_reg(REG_FULL_RANGE, {15'($urandom), full});
    write_reg(REG_DEPTH, {15'($urandom), depth});
    // ignored index
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_regions();
    int xs[] = '{0, 239, 240, 445, 446, 447, 960, 1197, 1336, 1473, 1679, 1680, 1919};
    int ys[] = '{0, 269, 270, 359, 360, 449, 450, 1079};
    idle_pct = 0;
    stall_pct = 0;
    foreach (xs[i]) send_pixel(16'(xs[i]), 16'(ys[i % 8]));
    send_pixel(16'h8000, 16'h8000);
    send_pixel(16'h7FFF, 16'h7FFF);
    send_pixel(16'h8000, 16'h7FFF);
    send_pixel(16'(1129), 16'(100));
    send_pixel(16'(1130), 16'(100));
    send_pixel(16'(700), 16'(300));
  endtask

  task automatic test_formats();
    for (int f = 0; f < 4; f++) begin
      configure(0, 0, 1920, 1080, (f == 3) ? 16'h7FFF : ((f == 1) ? 16'd0 : 16'd25600),
                f[0], f[1]);
      send_pixel(16'(1150), 16'(10));
      send_pixel(16'(1473), 16'(300));
      send_pixel(16'(500), 16'(900));
      send_pixel(16'(100), 16'(900));
      send_pixel(16'(1800), 16'(400));
    end
  endtask

  task automatic test_rect_edges();
    configure(16'h8000, 16'h7FFF, 16'd0, 16'd0, 16'd19200, 1'b0, 1'b1);
    send_pixel(16'h8000, 16'h7FFF);
    send_pixel(16'h7FFF, 16'h8000);
    configure(16'h7FFF, 16'h8000, 16'hFFFF, 16'd32768, 16'd9600, 1'b1, 1'b0);
    send_pixel(16'h8000, 16'h7FFF);
    send_pixel(16'h7FFF, 16'h8000);
    send_pixel(16'h0000, 16'h0000);
  endtask

  task automatic test_random();
    int unsigned modes[4][2] = '{'{0, 0}, '{87, 0}, '{0, 87}, '{15, 15}};
    logic [15:0] w, h, left, bottom, px, py;
    for (int ph = 0; ph < 8; ph++) begin
      w = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4000));
      h = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3000));
      left = 16'($urandom);
      bottom = 16'($urandom);
      configure(left, bottom, w, h,
                ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 25600)),
                $urandom_range(1), $urandom_range(1));
      idle_pct = modes[ph % 4][0];
      stall_pct = modes[ph % 4][1];
      repeat (190) begin
        if ($urandom_range(9) < 8) begin
          px = left + 16'($urandom_range(0, (w == 0) ? 0 : w - 1));
          py = bottom + 16'($urandom_range(0, (h == 0) ? 0 : h - 1));
        end else begin
          px = 16'($urandom);
          py = 16'($urandom);
        end
        send_pixel(px, py);
      end
    end
  endtask

  initial begin
    m_left = 0; m_bottom = 0; m_width = 1920; m_height = 1080;
    m_intensity = 19200; m_full_range = 0; m_depth = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_regions();
    test_formats();
    test_rect_edges();
    test_random();
    drain();
    $display("sent %0d pixels, checked %0d results over region edges, both ranges,",
             pixels_sent, pixels_checked);
    $display("both depths, degenerate rectangles and random configurations");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/chbg_pkg.sv
rtl/chbg_grid_div.sv
rtl/chbg_level.sv
rtl/chbg_code.sv
rtl/hd_color_bar_pattern_generator_unit.sv
test/hd_color_bar_pattern_generator_unit_test.sv
